/* sv/belsm_pkg.sv */
// Package for the big-endian load/store memory.
// Holds store geometry, access codes and the structs passed between stages.
// No dependencies.
package belsm_pkg;

	localparam int ADDR_W      = 11;
	localparam int MEM_BYTES   = 2048;
	localparam int NBANKS      = 8;
	localparam int BANK_W      = $clog2(NBANKS);
	localparam int ROWS        = MEM_BYTES / NBANKS;
	localparam int ROW_W       = $clog2(ROWS);
	localparam int EXT_W       = ADDR_W + 1;
	localparam int DATA_W      = 64;

	localparam logic [ADDR_W-1:0] CONSOLE_RESET = ADDR_W'(400);

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [1:0] SZ_1 = 2'd0;
	localparam logic [1:0] SZ_2 = 2'd1;
	localparam logic [1:0] SZ_4 = 2'd2;
	localparam logic [1:0] SZ_8 = 2'd3;

	typedef struct packed {
		logic             we;
		logic [ROW_W-1:0] row;
		logic [7:0]       wdata;
	} bank_req_t;

	typedef struct packed {
		logic              valid;
		logic              is_write;
		logic [1:0]        size;
		logic              sext;
		logic [BANK_W-1:0] lsb;
		logic              err;
		logic              cvalid;
		logic [7:0]        cbyte;
	} ctl_t;

endpackage

/* sv/belsm_bank.sv */
// One byte-wide bank of the store: one row address, write and registered read.
// Uses belsm_pkg for the row width and depth.
module belsm_bank
	import belsm_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [ROW_W-1:0] row,
	input  logic [7:0]       wdata,
	output logic [7:0]       rdata
);

	logic [7:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[row] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[row];
	end

endmodule

/* sv/belsm_decode.sv */
// Access decode: bounds check, console match and per-bank row, enable and data.
// Uses belsm_pkg; also drives the clearing sweep onto all banks.
module belsm_decode
	import belsm_pkg::*;
(
	input  logic              clearing,
	input  logic [ROW_W-1:0]  clr_row,
	input  logic              valid,
	input  logic              action,
	input  logic [1:0]        size_code,
	input  logic              sign_extend,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] write_value,
	input  logic [ADDR_W-1:0] console_address,
	output bank_req_t         req [NBANKS],
	output ctl_t              ctl
);

	logic [BANK_W:0]   n_bytes;
	logic [EXT_W-1:0]  end_addr;
	logic              err;
	logic              do_write;
	logic [BANK_W-1:0] lsb;
	logic [ROW_W-1:0]  row_base;

	always_comb begin
		n_bytes  = (BANK_W+1)'(1) << size_code;
		end_addr = {1'b0, address} + EXT_W'(n_bytes);
		err      = end_addr > EXT_W'(MEM_BYTES);
		do_write = valid && (action == ACT_WRITE) && !err;
		lsb      = address[BANK_W-1:0];
		row_base = address[ADDR_W-1:BANK_W];

		ctl.valid    = valid;
		ctl.is_write = (action == ACT_WRITE);
		ctl.size     = size_code;
		ctl.sext     = sign_extend;
		ctl.lsb      = lsb;
		ctl.err      = err;
		ctl.cvalid   = do_write && (size_code == SZ_4) && (address == console_address);
		ctl.cbyte    = ctl.cvalid ? write_value[7:0] : 8'd0;
	end

	always_comb begin
		logic [BANK_W-1:0] k;
		logic [BANK_W-1:0] j;
		for (int b = 0; b < NBANKS; b++) begin
			k = BANK_W'(b) - lsb;
			j = BANK_W'(n_bytes - (BANK_W+1)'(1) - {1'b0, k});
			if (clearing) begin
				req[b].we    = 1'b1;
				req[b].row   = clr_row;
				req[b].wdata = 8'd0;
			end else begin
				req[b].we    = do_write && ({1'b0, k} < n_bytes);
				req[b].row   = (BANK_W'(b) >= lsb) ? row_base : row_base + ROW_W'(1);
				req[b].wdata = write_value[{j, 3'b000} +: 8];
			end
		end
	end

endmodule

/* sv/belsm_align.sv */
// Load alignment: gathers bank bytes in big-endian order and extends them.
// Uses belsm_pkg for the control struct and size codes.
module belsm_align
	import belsm_pkg::*;
(
	input  ctl_t              ctl,
	input  logic [7:0]        rdata [NBANKS],
	output logic [DATA_W-1:0] read_value
);

	logic [DATA_W-1:0] raw;

	always_comb begin
		logic [BANK_W-1:0] idx;
		for (int k = 0; k < NBANKS; k++) begin
			idx = ctl.lsb + BANK_W'(k);
			raw[8*(NBANKS-1-k) +: 8] = rdata[idx];
		end
	end

	always_comb begin
		read_value = '0;
		if (!ctl.is_write && !ctl.err) begin
			unique case (ctl.size)
				SZ_1: read_value = {{56{ctl.sext & raw[63]}}, raw[63:56]};
				SZ_2: read_value = {{48{ctl.sext & raw[63]}}, raw[63:48]};
				SZ_4: read_value = {{32{ctl.sext & raw[63]}}, raw[63:32]};
				SZ_8: read_value = raw;
				default: read_value = '0;
			endcase
		end
	end

endmodule

/* sv/big_endian_load_store_memory_top.sv */
// Top level of the big-endian load/store memory: input stage, eight byte banks,
// alignment stage and result register. Uses belsm_pkg, belsm_decode, belsm_bank, belsm_align.
//
// channel   direction  handshake               payload
// command   in         start, accepted !busy   action, size_code, sign_extend, address,
//                                              write_value
// result    out        done, one cycle         read_value, access_error, console_valid,
//                                              console_byte
// config    in         cfg_write               cfg_data (console address)
//
// Unless busy, one transaction per cycle; done follows input, bank-read and result registers.
// The throughput is set by the eight byte banks, each one row access per cycle.
// After reset busy stays high while a sweep zeroes all 256 rows, one bank row a cycle.
// Config writes are taken during the sweep. Results cannot be stalled.
module big_endian_load_store_memory_top
	import belsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [1:0]        size_code,
	input  logic              sign_extend,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] write_value,
	output logic              done,
	output logic [DATA_W-1:0] read_value,
	output logic              access_error,
	output logic              console_valid,
	output logic [7:0]        console_byte,
	input  logic              cfg_write,
	input  logic [ADDR_W-1:0] cfg_data
);

	logic              clearing_q;
	logic [ROW_W-1:0]  clr_row_q;
	logic [ADDR_W-1:0] console_address_q;

	logic              valid_s1;
	logic              action_s1;
	logic [1:0]        size_code_s1;
	logic              sign_extend_s1;
	logic [ADDR_W-1:0] address_s1;
	logic [DATA_W-1:0] write_value_s1;

	ctl_t              ctl_s1;
	ctl_t              ctl_s2;
	bank_req_t         req [NBANKS];
	logic [7:0]        rdata [NBANKS];
	logic [DATA_W-1:0] read_value_c;

	logic              done_q;
	logic [DATA_W-1:0] read_value_q;
	logic              access_error_q;
	logic              console_valid_q;
	logic [7:0]        console_byte_q;

	assign busy = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			clr_row_q <= clr_row_q + ROW_W'(1);
			if (clr_row_q == ROW_W'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			console_address_q <= CONSOLE_RESET;
		end else if (cfg_write) begin
			console_address_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		action_s1      <= action;
		size_code_s1   <= size_code;
		sign_extend_s1 <= sign_extend;
		address_s1     <= address;
		write_value_s1 <= write_value;
	end

	belsm_decode u_decode (
		.clearing        (clearing_q),
		.clr_row         (clr_row_q),
		.valid           (valid_s1),
		.action          (action_s1),
		.size_code       (size_code_s1),
		.sign_extend     (sign_extend_s1),
		.address         (address_s1),
		.write_value     (write_value_s1),
		.console_address (console_address_q),
		.req             (req),
		.ctl             (ctl_s1)
	);

	for (genvar b = 0; b < NBANKS; b++) begin : g_bank
		belsm_bank u_bank (
			.clk   (clk),
			.we    (req[b].we),
			.row   (req[b].row),
			.wdata (req[b].wdata),
			.rdata (rdata[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	belsm_align u_align (
		.ctl        (ctl_s2),
		.rdata      (rdata),
		.read_value (read_value_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		read_value_q    <= read_value_c;
		access_error_q  <= ctl_s2.err;
		console_valid_q <= ctl_s2.cvalid;
		console_byte_q  <= ctl_s2.cbyte;
	end

	assign done          = done_q;
	assign read_value    = read_value_q;
	assign access_error  = access_error_q;
	assign console_valid = console_valid_q;
	assign console_byte  = console_byte_q;

endmodule

/* sv/belsm_checker.sv */
// Port-level checks for the big-endian load/store memory, bound to the top level.
// Uses belsm_pkg for field widths.
module belsm_checker
	import belsm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [DATA_W-1:0] read_value,
	input logic              access_error,
	input logic              console_valid,
	input logic [7:0]        console_byte
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("accepted transaction gave no result three cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without an accepted transaction");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && access_error |-> !console_valid && read_value == '0)
		else $error("out-of-range access returned data or console output");

	a_console_write: assert property (@(posedge clk) disable iff (!arst_n)
		done && console_valid |-> read_value == '0)
		else $error("console write returned read data");

	a_console_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && !console_valid |-> console_byte == 8'd0)
		else $error("console byte set without console output");

endmodule

bind big_endian_load_store_memory_top belsm_checker u_belsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.read_value    (read_value),
	.access_error  (access_error),
	.console_valid (console_valid),
	.console_byte  (console_byte)
);

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for big_endian_load_store_memory_top: a directed table,
// then random phases. Each phase sets a new console address.
// Depends on belsm_pkg and the RTL top level only.
module tb_top;
	import belsm_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 160;
	localparam int DIR_N       = 27;

	typedef struct packed {
		logic              action;
		logic [1:0]        size;
		logic              sext;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wval;
	} access_t;

	typedef struct packed {
		logic [DATA_W-1:0] rval;
		logic              err;
		logic              cvalid;
		logic [7:0]        cbyte;
	} outcome_t;

	typedef struct packed {
		access_t  acc;
		logic     known;
		outcome_t res;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              action;
	logic [1:0]        size_code;
	logic              sign_extend;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_value;
	logic              done;
	logic [DATA_W-1:0] read_value;
	logic              access_error;
	logic              console_valid;
	logic [7:0]        console_byte;
	logic              cfg_write;
	logic [ADDR_W-1:0] cfg_data;

	logic              row_known;
	outcome_t          row_res;

	logic [7:0]        store_model [MEM_BYTES];
	logic [ADDR_W-1:0] console_model;
	outcome_t          outcome_q [$];
	outcome_t          seen_exp;
	outcome_t          seen_pred;
	int                err_cnt;
	int                stall_cycles;
	logic [ADDR_W-1:0] phase_con;

	localparam outcome_t ZERO_RES = '{64'd0, 1'b0, 1'b0, 8'd0};
	localparam outcome_t ERR_RES  = '{64'd0, 1'b1, 1'b0, 8'd0};

	dir_row_t dir_tab [DIR_N] = '{
		'{'{ACT_READ,  SZ_8, 1'b0, 11'd0,    64'd0},                 1'b1, ZERO_RES},
		'{'{ACT_READ,  SZ_1, 1'b1, 11'd2047, 64'd0},                 1'b1, ZERO_RES},
		'{'{ACT_READ,  SZ_2, 1'b1, 11'd2047, 64'd0},                 1'b1, ERR_RES},
		'{'{ACT_READ,  SZ_4, 1'b0, 11'd2045, 64'd0},                 1'b1, ERR_RES},
		'{'{ACT_READ,  SZ_8, 1'b1, 11'd2041, 64'd0},                 1'b1, ERR_RES},
		'{'{ACT_WRITE, SZ_8, 1'b0, 11'd2041, 64'hffffffffffffffff},  1'b1, ERR_RES},
		'{'{ACT_WRITE, SZ_4, 1'b1, 11'd2045, 64'hffffffffffffffff},  1'b1, ERR_RES},
		'{'{ACT_READ,  SZ_8, 1'b0, 11'd2040, 64'd0},                 1'b1, ZERO_RES},
		'{'{ACT_WRITE, SZ_8, 1'b0, 11'd2040, 64'h8091a2b3c4d5e6f7},  1'b1, ZERO_RES},
		'{'{ACT_READ,  SZ_8, 1'b0, 11'd2040, 64'd0},                 1'b1,
			'{64'h8091a2b3c4d5e6f7, 1'b0, 1'b0, 8'd0}},
		'{'{ACT_READ,  SZ_1, 1'b1, 11'd2040, 64'd0},                 1'b1,
			'{64'hffffffffffffff80, 1'b0, 1'b0, 8'd0}},
		'{'{ACT_READ,  SZ_1, 1'b0, 11'd2040, 64'd0},                 1'b1,
			'{64'h0000000000000080, 1'b0, 1'b0, 8'd0}},
		'{'{ACT_READ,  SZ_2, 1'b1, 11'd2040, 64'd0},                 1'b0, ZERO_RES},
		'{'{ACT_READ,  SZ_4, 1'b1, 11'd2041, 64'd0},                 1'b0, ZERO_RES},
		'{'{ACT_READ,  SZ_4, 1'b0, 11'd2044, 64'd0},                 1'b0, ZERO_RES},
		'{'{ACT_READ,  SZ_8, 1'b1, 11'd2040, 64'd0},                 1'b0, ZERO_RES},
		'{'{ACT_WRITE, SZ_4, 1'b0, 11'd400,  64'h0123456789abcd41},  1'b1,
			'{64'd0, 1'b0, 1'b1, 8'h41}},
		'{'{ACT_WRITE, SZ_2, 1'b0, 11'd400,  64'h000000000000ffff},  1'b1, ZERO_RES},
		'{'{ACT_WRITE, SZ_1, 1'b1, 11'd400,  64'h0000000000000055},  1'b1, ZERO_RES},
		'{'{ACT_WRITE, SZ_8, 1'b0, 11'd400,  64'hfedcba9876543210},  1'b1, ZERO_RES},
		'{'{ACT_WRITE, SZ_4, 1'b0, 11'd401,  64'h00000000000000aa},  1'b1, ZERO_RES},
		'{'{ACT_READ,  SZ_8, 1'b1, 11'd400,  64'd0},                 1'b0, ZERO_RES},
		'{'{ACT_WRITE, SZ_4, 1'b0, 11'd0,    64'h000000007fffffff},  1'b0, ZERO_RES},
		'{'{ACT_READ,  SZ_4, 1'b1, 11'd0,    64'd0},                 1'b0, ZERO_RES},
		'{'{ACT_READ,  SZ_2, 1'b1, 11'd1,    64'd0},                 1'b0, ZERO_RES},
		'{'{ACT_WRITE, SZ_1, 1'b0, 11'd2047, 64'h00000000000000ff},  1'b0, ZERO_RES},
		'{'{ACT_READ,  SZ_1, 1'b1, 11'd2047, 64'd0},                 1'b0, ZERO_RES}
	};

	big_endian_load_store_memory_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.size_code     (size_code),
		.sign_extend   (sign_extend),
		.address       (address),
		.write_value   (write_value),
		.done          (done),
		.read_value    (read_value),
		.access_error  (access_error),
		.console_valid (console_valid),
		.console_byte  (console_byte),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic outcome_t memory_access(access_t a);
		outcome_t r;
		int n;
		r = ZERO_RES;
		n = 1 << a.size;
		if (int'(a.addr) + n > MEM_BYTES) begin
			r.err = 1'b1;
		end else if (a.action == ACT_WRITE) begin
			for (int k = 0; k < n; k++)
				store_model[int'(a.addr) + k] = 8'(a.wval >> (8 * (n - 1 - k)));
			if (a.size == SZ_4 && a.addr == console_model) begin
				r.cvalid = 1'b1;
				r.cbyte  = a.wval[7:0];
			end
		end else begin
			for (int k = 0; k < n; k++)
				r.rval = (r.rval << 8) | DATA_W'(store_model[int'(a.addr) + k]);
			if (a.size != SZ_8 && a.sext && r.rval[8 * n - 1])
				r.rval = r.rval | ~((64'd1 << (8 * n)) - 64'd1);
		end
		return r;
	endfunction

	function automatic access_t random_access();
		access_t a;
		int sel;
		sel = $urandom_range(99);
		a.action = 1'($urandom_range(1));
		a.size   = 2'($urandom_range(3));
		a.sext   = 1'($urandom_range(1));
		a.wval   = {$urandom, $urandom};
		if (sel < 40) begin
			a.addr = ADDR_W'($urandom_range(47));
		end else if (sel < 55) begin
			a.addr = ADDR_W'($urandom_range(MEM_BYTES - 1, MEM_BYTES - 12));
		end else if (sel < 70) begin
			a.addr   = phase_con;
			a.action = ($urandom_range(3) != 0) ? ACT_WRITE : ACT_READ;
			if ($urandom_range(2) != 0)
				a.size = SZ_4;
		end else begin
			a.addr = ADDR_W'($urandom);
		end
		return a;
	endfunction

	task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			err_cnt++;
			$display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result with none expected, expected none got %h %b %b %h",
						$time, read_value, access_error, console_valid, console_byte);
				end else begin
					seen_exp = outcome_q.pop_front();
					check_field("read_value", seen_exp.rval, read_value);
					check_field("access_error", DATA_W'(seen_exp.err), DATA_W'(access_error));
					check_field("console_valid", DATA_W'(seen_exp.cvalid), DATA_W'(console_valid));
					check_field("console_byte", DATA_W'(seen_exp.cbyte), DATA_W'(console_byte));
				end
			end
			if (cfg_write)
				console_model = cfg_data;
			if (start && !busy) begin
				seen_pred = memory_access('{action, size_code, sign_extend, address, write_value});
				outcome_q = {outcome_q, (row_known ? row_res : seen_pred)};
			end
		end
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send(access_t a, logic known, outcome_t res);
		action      <= a.action;
		size_code   <= a.size;
		sign_extend <= a.sext;
		address     <= a.addr;
		write_value <= a.wval;
		row_known   <= known;
		row_res     <= res;
		start       <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic set_console(logic [ADDR_W-1:0] value);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	logic [ADDR_W-1:0] con_list [PHASES];

	initial begin
		arst_n        <= 1'b0;
		start         <= 1'b0;
		action        <= ACT_READ;
		size_code     <= SZ_1;
		sign_extend   <= 1'b0;
		address       <= '0;
		write_value   <= '0;
		cfg_write     <= 1'b0;
		cfg_data      <= '0;
		row_known     <= 1'b0;
		row_res       <= ZERO_RES;
		err_cnt       = 0;
		stall_cycles  = 0;
		console_model = CONSOLE_RESET;
		phase_con     = CONSOLE_RESET;
		for (int i = 0; i < MEM_BYTES; i++)
			store_model[i] = 8'd0;
		con_list = '{11'd0, 11'd2047, 11'd2044, 11'($urandom), 11'd1, CONSOLE_RESET,
			11'($urandom), 11'd1024};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send(dir_tab[i].acc, dir_tab[i].known, dir_tab[i].res);
		start <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			phase_con = con_list[p];
			set_console(phase_con);
			@(posedge clk);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold off the next transaction for a short burst
				if (p < PHASES - 1 && p != 2 && $urandom_range(3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(7, 1)) @(posedge clk);
				end
				send(random_access(), 1'b0, ZERO_RES);
			end
			start <= 1'b0;
		end

		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* filelist.f */
sv/belsm_pkg.sv
sv/belsm_bank.sv
sv/belsm_decode.sv
sv/belsm_align.sv
sv/big_endian_load_store_memory_top.sv
sv/belsm_checker.sv
dv/tb_top.sv
